/* src/nearest_k_sorted_list_unit_macros.svh */
// Assertion macros shared by the checker of the nearest-K list unit.
// Needs no other file; include it by its bare file name.
`ifndef NEAREST_K_SORTED_LIST_UNIT_MACROS_SVH
`define NEAREST_K_SORTED_LIST_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define NKSL_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// A stalled request must keep its valid and its payload.
`define NKSL_ASSERT_HOLD(label, clk, rstn, vld, rdy, sig, msg) \
  `NKSL_ASSERT_CLK(label, clk, rstn, vld && !rdy |=> vld && $stable(sig), msg)

`endif

/* src/nksl_pkg.sv */
// Shared constants and types of the nearest-K sorted list unit.
// Has no dependencies; every other file but the macros header imports it.
package nksl_pkg;

  // Fixed field widths.
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned DMG_W     = 16;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Command codes carried in the input tuser.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_OFFER  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd1;

  // Per-cycle command to every cell of the chain.
  typedef struct packed {
    logic offer;   // insert the broadcast candidate
    logic rotate;  // every cell takes its right neighbor's entry
  } nksl_ctrl_t;

endpackage

/* src/nksl_cell.sv */
// One cell of the sorted chain: holds a single list entry.
// Depends on nksl_pkg.
module nksl_cell import nksl_pkg::*; #(
  parameter int unsigned DIST_BITS = 16
) (
  input  logic                 clk_i,
  input  nksl_ctrl_t           ctrl_i,
  input  logic                 valid_i,
  input  logic                 take_prev_i,
  output logic                 take_o,
  input  logic [DIST_BITS-1:0] cand_dist_i,
  input  logic [ID_W-1:0]      cand_id_i,
  input  logic [DIST_BITS-1:0] prev_dist_i,
  input  logic [ID_W-1:0]      prev_id_i,
  input  logic [DIST_BITS-1:0] next_dist_i,
  input  logic [ID_W-1:0]      next_id_i,
  output logic [DIST_BITS-1:0] dist_o,
  output logic [ID_W-1:0]      id_o
);

  logic [DIST_BITS-1:0] dist_q, dist_d;
  logic [ID_W-1:0]      id_q, id_d;

  // This slot is where the candidate belongs, or lies behind it: it is free
  // or holds a strictly farther entry.
  assign take_o = !valid_i || (dist_q > cand_dist_i);

  // Shift in from the left when the slot before also moves, load the
  // candidate at the insertion point, or rotate toward cell zero.
  always_comb begin
    dist_d = dist_q;
    id_d   = id_q;
    if (ctrl_i.offer) begin
      if (take_prev_i) begin
        dist_d = prev_dist_i;
        id_d   = prev_id_i;
      end else if (take_o) begin
        dist_d = cand_dist_i;
        id_d   = cand_id_i;
      end
    end else if (ctrl_i.rotate) begin
      dist_d = next_dist_i;
      id_d   = next_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    id_q   <= id_d;
  end

  assign dist_o = dist_q;
  assign id_o   = id_q;

endmodule

/* src/nksl_div.sv */
// Restoring divider, one quotient bit per cycle, for the damage falloff.
// Depends on nksl_pkg. The quotient must fit in DMG_W bits.
module nksl_div import nksl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2*DMG_W-1:0]   num_i,
  input  logic [DMG_W-1:0]     den_i,
  output logic                 busy_o,
  output logic [DMG_W-1:0]     quo_o
);

  localparam int unsigned CntW = $clog2(DMG_W);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DMG_W-1:0] rem_q, rem_d;
  logic [DMG_W-1:0] quo_q, quo_d;
  logic [DMG_W:0]   trial;
  logic [DMG_W:0]   diff;
  logic             ge;

  // Bring down the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[DMG_W-1]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = trial >= {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DMG_W - 1);
      rem_d  = num_i[2*DMG_W-1:DMG_W];
      quo_d  = num_i[DMG_W-1:0];
    end else if (busy_q) begin
      rem_d = ge ? diff[DMG_W-1:0] : trial[DMG_W-1:0];
      quo_d = {quo_q[DMG_W-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

/* src/nearest_k_sorted_list_unit.sv */
// Top level of the nearest-K sorted list unit: cell chain, report sequencer,
// falloff multiplier and divider. Depends on nksl_pkg, nksl_cell, nksl_div.
//
//  channel  | dir | handshake                    | content
//  ---------+-----+------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: unit_id, distance; tuser: func
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: unit, dist, damage, index
//  cfg      | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// Clear and offer requests complete in the idle state; the chain inserts in parallel.
// A report waits on the falloff divider for each entry and then emits it, and
// the chain rotates a full turn so the list is back in place.
// An empty report gives a single result flagged empty.
// Reset empties the list, sets the range to 1 and the base damage to 0.
// A stalled output holds the sequencer where it would load a result, and the result register stays loaded.
module nearest_k_sorted_list_unit import nksl_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 8,
  parameter int unsigned DIST_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Request channel.
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Bits from 0 up: unit_id, distance, zero fill.
  input  logic [((ID_W+DIST_BITS+7)/8)*8-1:0] s_axis_tdata,
  // Bits from 0 up: func.
  input  logic [FUNC_W-1:0] s_axis_tuser,
  // Result channel.
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // Bits from 0 up: out_unit, out_distance, out_damage, entry_index, zero fill.
  output logic [((ID_W+DIST_BITS+DMG_W+IDX_W+7)/8)*8-1:0] m_axis_tdata,
  // Bits from 0 up: list_empty.
  output logic m_axis_tuser,
  output logic m_axis_tlast,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CntW  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CmpW  = (DIST_BITS > DMG_W) ? DIST_BITS : DMG_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_SPIN  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] step_q, step_d;
  logic [CntW-1:0] step_inc;
  logic [CFG_W-1:0] range_q, base_q;

  logic [ID_W-1:0]      in_id;
  logic [DIST_BITS-1:0] in_dist;
  logic                 in_acc;
  nksl_ctrl_t           ctrl;

  logic [DIST_BITS-1:0] cell_dist [LIST_DEPTH];
  logic [ID_W-1:0]      cell_id   [LIST_DEPTH];
  logic                 cell_take [LIST_DEPTH];

  logic [ID_W-1:0]      hold_id_q;
  logic [DIST_BITS-1:0] hold_dist_q;
  logic [DMG_W-1:0]     diff_q;
  logic [2*DMG_W-1:0]   prod;
  logic                 near;
  logic [CmpW-1:0]      head_dist_x, range_x, diff_x;
  logic                 div_start, div_busy;
  logic [DMG_W-1:0]     div_quo;

  logic                 out_free, load_out, load_empty, last_now;
  logic                 m_valid_q, m_valid_d;
  logic [ID_W-1:0]      o_id_q;
  logic [DIST_BITS-1:0] o_dist_q;
  logic [DMG_W-1:0]     o_dmg_q;
  logic [IDX_W-1:0]     o_idx_q;
  logic                 o_empty_q, o_last_q;

  // Request unpacking.
  assign in_id   = s_axis_tdata[ID_W-1:0];
  assign in_dist = s_axis_tdata[ID_W+DIST_BITS-1:ID_W];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // The chain of cells; cell zero holds the nearest entry.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic valid;
    assign valid = count_q > CntW'(i);
    if (i == 0) begin : g_head
      nksl_cell #(.DIST_BITS(DIST_BITS)) u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .valid_i     (valid),
        .take_prev_i (1'b0),
        .take_o      (cell_take[i]),
        .cand_dist_i (in_dist),
        .cand_id_i   (in_id),
        .prev_dist_i (in_dist),
        .prev_id_i   (in_id),
        .next_dist_i (cell_dist[(i+1) % LIST_DEPTH]),
        .next_id_i   (cell_id[(i+1) % LIST_DEPTH]),
        .dist_o      (cell_dist[i]),
        .id_o        (cell_id[i])
      );
    end else begin : g_body
      nksl_cell #(.DIST_BITS(DIST_BITS)) u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .valid_i     (valid),
        .take_prev_i (cell_take[i-1]),
        .take_o      (cell_take[i]),
        .cand_dist_i (in_dist),
        .cand_id_i   (in_id),
        .prev_dist_i (cell_dist[i-1]),
        .prev_id_i   (cell_id[i-1]),
        .next_dist_i (cell_dist[(i+1) % LIST_DEPTH]),
        .next_id_i   (cell_id[(i+1) % LIST_DEPTH]),
        .dist_o      (cell_dist[i]),
        .id_o        (cell_id[i])
      );
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;
  assign step_inc = step_q + CntW'(1);
  assign last_now = (step_inc == count_q);

  // Sequencer: list updates in the idle state, and per-entry report steps.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    step_d     = step_q;
    ctrl       = '0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    load_empty = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            FUNC_CLEAR: begin
              count_d = '0;
            end
            FUNC_OFFER: begin
              ctrl.offer = 1'b1;
              if (count_q < CntW'(LIST_DEPTH)) begin
                count_d = count_q + CntW'(1);
              end
            end
            FUNC_REPORT: begin
              state_d = ST_START;
              step_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_START: begin
        if (count_q == '0) begin
          if (out_free) begin
            load_empty = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out    = 1'b1;
          ctrl.rotate = 1'b1;
          step_d      = step_inc;
          if (!last_now) begin
            state_d = ST_START;
          end else if (count_q == CntW'(LIST_DEPTH)) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_SPIN;
          end
        end
      end
      ST_SPIN: begin
        // Finish the full turn so the list is back in order.
        ctrl.rotate = 1'b1;
        step_d      = step_inc;
        if (step_q == CntW'(LIST_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
    end
  end

  // Configuration registers; a zero range is stored as one.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= CFG_W'(1);
      base_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RANGE: range_q <= (cfg_data_i == '0) ? CFG_W'(1) : cfg_data_i;
        CFG_BASE:  base_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Head entry capture and the distance left to the edge of the blast.
  assign head_dist_x = CmpW'(cell_dist[0]);
  assign range_x     = CmpW'(range_q);
  assign near        = head_dist_x < range_x;
  assign diff_x      = range_x - head_dist_x;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_START) begin
      hold_id_q   <= cell_id[0];
      hold_dist_q <= cell_dist[0];
      diff_q      <= near ? diff_x[DMG_W-1:0] : '0;
    end
  end

  // Falloff: base * (range - d), divided by range in the restoring divider.
  assign prod = base_q * diff_q;

  nksl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .den_i   (range_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // Result register.
  always_comb begin
    m_valid_d = m_valid_q;
    if (load_out || load_empty) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_empty) begin
      o_id_q    <= '0;
      o_dist_q  <= '0;
      o_dmg_q   <= '0;
      o_idx_q   <= '0;
      o_empty_q <= 1'b1;
      o_last_q  <= 1'b1;
    end else if (load_out) begin
      o_id_q    <= hold_id_q;
      o_dist_q  <= hold_dist_q;
      o_dmg_q   <= div_quo;
      o_idx_q   <= IDX_W'(step_q);
      o_empty_q <= 1'b0;
      o_last_q  <= last_now;
    end
  end

  // Result packing.
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[ID_W-1:0]                     = o_id_q;
    m_axis_tdata[ID_W+DIST_BITS-1:ID_W]        = o_dist_q;
    m_axis_tdata[ID_W+DIST_BITS+DMG_W-1:ID_W+DIST_BITS] = o_dmg_q;
    m_axis_tdata[ID_W+DIST_BITS+DMG_W+IDX_W-1:ID_W+DIST_BITS+DMG_W] = o_idx_q;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = o_empty_q;
  assign m_axis_tlast  = o_last_q;

endmodule

/* src/nksl_checker.sv */
// Port-level checker for the nearest-K sorted list unit, bound to the top.
// Depends on nksl_pkg and nearest_k_sorted_list_unit_macros.svh.
`include "nearest_k_sorted_list_unit_macros.svh"

module nksl_checker import nksl_pkg::*; #(
  parameter int unsigned DIST_BITS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [FUNC_W-1:0] s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((ID_W+DIST_BITS+DMG_W+IDX_W+7)/8)*8-1:0] m_axis_tdata,
  input logic m_axis_tuser,
  input logic m_axis_tlast
);

  // A stalled result keeps its payload.
  `NKSL_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata, "result changed while stalled")

  // An empty-list result is the only and last one of its report, with zero fields.
  `NKSL_ASSERT_CLK(a_empty_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0), "empty result malformed")

  // A report request occupies the unit, so no request is taken in the next cycle.
  `NKSL_ASSERT_CLK(a_report_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_REPORT) |=> !s_axis_tready, "request taken during report")

endmodule

bind nearest_k_sorted_list_unit nksl_checker #(.DIST_BITS(DIST_BITS)) u_nksl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
